[src/skpl_pkg.sv]
//------------------------------------------------------------------------------
// skpl_pkg
// Shared types and constants for the sorted key position lookup block.
//------------------------------------------------------------------------------
`default_nettype none
package skpl_pkg;
    localparam int TableDepthDefault = 1024;
    localparam int KeyBitsDefault    = 32;
    localparam int InKeyBits         = 32;
    localparam int PosBits           = 10;

    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_INIT,
        ST_MRG_RD,
        ST_MRG_WAIT,
        ST_MRG_CMP,
        ST_CPY_RD,
        ST_CPY_WAIT,
        ST_CPY_WR,
        ST_SRCH_INIT,
        ST_SRCH_RD,
        ST_SRCH_WAIT,
        ST_SRCH_CMP,
        ST_RESULT
    } state_t;
endpackage
`default_nettype wire

[src/skpl_req_if.sv]
//------------------------------------------------------------------------------
// skpl_req_if
// Request channel: valid/ready with request type and key.
//------------------------------------------------------------------------------
`default_nettype none
interface skpl_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] key;
    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface
`default_nettype wire

[src/skpl_rsp_if.sv]
//------------------------------------------------------------------------------
// skpl_rsp_if
// Result channel: valid/ready with found flag and position.
//------------------------------------------------------------------------------
`default_nettype none
interface skpl_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [9:0] position;
    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface
`default_nettype wire

[src/skpl_mem.sv]
//------------------------------------------------------------------------------
// skpl_mem
// Single-port synchronous RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module skpl_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 42
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end
endmodule
`default_nettype wire

[src/sorted_key_position_lookup_core.sv]
//------------------------------------------------------------------------------
// sorted_key_position_lookup_core
// Key table with bottom-up merge sort and binary search lookup.
//------------------------------------------------------------------------------
// Usage:
//   req  : load (req_type=0) stores the key with its arrival position; loads
//          past TABLE_DEPTH are dropped. Query (req_type=1) returns one result.
//   rsp  : found and position of the first matching binary-search probe.
// Operation:
//   A load is written in its accept cycle, so loads can follow back to back.
//   A query on a sorted table is accepted, set up, then binary searched:
//   each probe sets the address, reads the RAM and compares, and a result
//   step ends the query. The first query after loads also sorts the table:
//   each bottom-up merge pass merges pairs of runs into the scratch RAM and
//   copies them back to the table, over ceil(log2(N)) passes. The one
//   comparator and single-port table/scratch RAMs carry out this work.
// Reset: count clears, table counts as sorted; RAM contents are not cleared.
// Stall: the result sits in an output register until taken; no new request
//   is accepted meanwhile.
//------------------------------------------------------------------------------
`default_nettype none
module sorted_key_position_lookup_core #(
    parameter int TABLE_DEPTH = skpl_pkg::TableDepthDefault,
    parameter int KEY_BITS    = skpl_pkg::KeyBitsDefault
) (
    input wire logic clk,
    input wire logic rst_n,
    skpl_req_if.sink   req,
    skpl_rsp_if.source rsp
);
    import skpl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int EW = KEY_BITS + PosBits;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          sorted_reg, sorted_next;
    logic signed [KEY_BITS-1:0] qkey_reg, qkey_next;
    // merge indices; CW wide so ends can equal count
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next, mid_reg, mid_next, hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic          side_reg, side_next;   // 0: reading run i, 1: run j
    logic [EW-1:0] ei_reg, ei_next, ej_reg, ej_next;
    logic          have_i_reg, have_i_next, have_j_reg, have_j_next;
    logic signed [CW:0] blo_reg, blo_next, bhi_reg, bhi_next;
    logic [CW-1:0] bmid_reg, bmid_next;
    logic          found_reg, found_next;
    logic [PosBits-1:0] pos_reg, pos_next;

    // RAM ports
    logic          t_we, s_we;
    logic [AW-1:0] t_addr, s_addr;
    logic [EW-1:0] t_wd, s_wd, t_rd, s_rd;

    skpl_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_table (
        .clk(clk), .wr_en(t_we), .addr(t_addr), .wr_data(t_wd), .rd_data(t_rd));
    skpl_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_scratch (
        .clk(clk), .wr_en(s_we), .addr(s_addr), .wr_data(s_wd), .rd_data(s_rd));

    logic signed [KEY_BITS-1:0] in_key;
    assign in_key = KEY_BITS <= InKeyBits ? req.key[KEY_BITS-1:0]
                                          : KEY_BITS'($signed(req.key));

    logic accept;
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_RESULT);
    assign rsp.found    = found_reg;
    assign rsp.position = pos_reg;

    // key fields of held entries
    logic signed [KEY_BITS-1:0] ki, kj, kt;
    assign ki = $signed(ei_reg[EW-1:PosBits]);
    assign kj = $signed(ej_reg[EW-1:PosBits]);
    assign kt = $signed(t_rd[EW-1:PosBits]);

    logic [CW:0] two_w;
    assign two_w = {width_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            sorted_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sorted_reg <= sorted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qkey_reg   <= qkey_next;
        width_reg  <= width_next;
        lo_reg     <= lo_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        side_reg   <= side_next;
        ei_reg     <= ei_next;
        ej_reg     <= ej_next;
        have_i_reg <= have_i_next;
        have_j_reg <= have_j_next;
        blo_reg    <= blo_next;
        bhi_reg    <= bhi_next;
        bmid_reg   <= bmid_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.req_type == REQ_QUERY)
                begin
                    state_next = sorted_reg ? ST_SRCH_INIT : ST_SORT_INIT;
                end
            end
            ST_SORT_INIT: state_next = ST_MRG_RD;
            ST_MRG_RD:
            begin
                if ({1'b0, width_reg} >= {1'b0, count_reg})
                begin
                    state_next = ST_SRCH_INIT;
                end
                else if ({1'b0, lo_reg} + {1'b0, width_reg} >= {1'b0, count_reg})
                begin
                    state_next = ST_MRG_RD;    // pass done, next width
                end
                else if (k_reg == hi_reg)
                begin
                    state_next = ST_CPY_RD;
                end
                else if ((side_reg == 1'b0 && !have_i_reg && i_reg < mid_reg) ||
                         (side_reg == 1'b1 && !have_j_reg && j_reg < hi_reg))
                begin
                    state_next = ST_MRG_WAIT;
                end
                else
                begin
                    state_next = ST_MRG_CMP;
                end
            end
            ST_MRG_WAIT: state_next = ST_MRG_RD;
            ST_MRG_CMP:  state_next = ST_MRG_RD;
            ST_CPY_RD:   state_next = (k_reg == hi_reg) ? ST_MRG_RD : ST_CPY_WAIT;
            ST_CPY_WAIT: state_next = ST_CPY_WR;
            ST_CPY_WR:   state_next = ST_CPY_RD;
            ST_SRCH_INIT: state_next = ST_SRCH_RD;
            ST_SRCH_RD:  state_next = (blo_reg <= bhi_reg) ? ST_SRCH_WAIT : ST_RESULT;
            ST_SRCH_WAIT: state_next = ST_SRCH_CMP;
            ST_SRCH_CMP: state_next = (kt == qkey_reg) ? ST_RESULT : ST_SRCH_RD;
            ST_RESULT:   state_next = rsp.ready ? ST_IDLE : ST_RESULT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        count_next  = count_reg;
        sorted_next = sorted_reg;
        qkey_next   = qkey_reg;
        width_next  = width_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        side_next   = side_reg;
        ei_next     = ei_reg;
        ej_next     = ej_reg;
        have_i_next = have_i_reg;
        have_j_next = have_j_reg;
        blo_next    = blo_reg;
        bhi_next    = bhi_reg;
        bmid_next   = bmid_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        t_we   = 1'b0;
        s_we   = 1'b0;
        t_addr = AW'(k_reg);
        s_addr = AW'(k_reg);
        t_wd   = s_rd;
        s_wd   = ei_reg;
        case (state_reg)
            ST_IDLE:
            begin
                t_addr = AW'(count_reg);
                t_wd   = {in_key, PosBits'(count_reg)};
                if (accept)
                begin
                    if (req.req_type == REQ_LOAD)
                    begin
                        if (count_reg < CW'(TABLE_DEPTH))
                        begin
                            t_we        = 1'b1;
                            count_next  = count_reg + 1'b1;
                            sorted_next = 1'b0;
                        end
                    end
                    else
                    begin
                        qkey_next = in_key;
                    end
                end
            end
            ST_SORT_INIT:
            begin
                width_next  = CW'(1);
                lo_next     = '0;
                mid_next    = CW'(1);
                hi_next     = (count_reg > CW'(2)) ? CW'(2) : count_reg;
                i_next      = '0;
                j_next      = CW'(1);
                k_next      = '0;
                side_next   = 1'b0;
                have_i_next = 1'b0;
                have_j_next = 1'b0;
            end
            ST_MRG_RD:
            begin
                if ({1'b0, width_reg} >= {1'b0, count_reg})
                begin
                    sorted_next = 1'b1;
                end
                else if ({1'b0, lo_reg} + {1'b0, width_reg} >= {1'b0, count_reg})
                begin
                    // start next pass
                    width_next  = CW'(two_w);
                    lo_next     = '0;
                    mid_next    = CW'(two_w);
                    hi_next     = ({1'b0, count_reg} - two_w > two_w) ?
                                  CW'({two_w, 1'b0}) : count_reg;
                    i_next      = '0;
                    j_next      = CW'(two_w);
                    k_next      = '0;
                    side_next   = 1'b0;
                    have_i_next = 1'b0;
                    have_j_next = 1'b0;
                end
                else if (k_reg == hi_reg)
                begin
                    k_next = lo_reg;
                end
                else if (side_reg == 1'b0 && !have_i_reg && i_reg < mid_reg)
                begin
                    t_addr = AW'(i_reg);
                end
                else if (side_reg == 1'b1 && !have_j_reg && j_reg < hi_reg)
                begin
                    t_addr = AW'(j_reg);
                end
            end
            ST_MRG_WAIT:
            begin
                if (side_reg == 1'b0)
                begin
                    ei_next     = t_rd;
                    have_i_next = 1'b1;
                end
                else
                begin
                    ej_next     = t_rd;
                    have_j_next = 1'b1;
                end
                side_next = ~side_reg;
            end
            ST_MRG_CMP:
            begin
                side_next = ~side_reg;
                if (have_i_reg && (!have_j_reg || ki <= kj))
                begin
                    s_we        = 1'b1;
                    s_wd        = ei_reg;
                    have_i_next = 1'b0;
                    i_next      = i_reg + 1'b1;
                    k_next      = k_reg + 1'b1;
                    side_next   = 1'b0;
                end
                else if (have_j_reg)
                begin
                    s_we        = 1'b1;
                    s_wd        = ej_reg;
                    have_j_next = 1'b0;
                    j_next      = j_reg + 1'b1;
                    k_next      = k_reg + 1'b1;
                    side_next   = 1'b1;
                end
            end
            ST_CPY_RD:
            begin
                if (k_reg == hi_reg)
                begin
                    // next run pair
                    lo_next     = lo_reg + CW'(two_w);
                    mid_next    = lo_reg + CW'(two_w) + width_reg;
                    i_next      = lo_reg + CW'(two_w);
                    j_next      = lo_reg + CW'(two_w) + width_reg;
                    k_next      = lo_reg + CW'(two_w);
                    hi_next     = ({1'b0, lo_reg} + two_w + {1'b0, width_reg}
                                   >= {1'b0, count_reg}) ? count_reg :
                                  (({1'b0, count_reg} - ({1'b0, lo_reg} + two_w
                                   + {1'b0, width_reg}) > {1'b0, width_reg}) ?
                                   lo_reg + CW'(two_w) + CW'(two_w) : count_reg);
                    side_next   = 1'b0;
                    have_i_next = 1'b0;
                    have_j_next = 1'b0;
                end
            end
            ST_CPY_WAIT: ;
            ST_CPY_WR:
            begin
                t_we   = 1'b1;
                t_wd   = s_rd;
                k_next = k_reg + 1'b1;
            end
            ST_SRCH_INIT:
            begin
                blo_next   = '0;
                bhi_next   = $signed({1'b0, count_reg} - (CW+1)'(1));
                found_next = 1'b0;
                pos_next   = '0;
            end
            ST_SRCH_RD:
            begin
                bmid_next = CW'((blo_reg + bhi_reg) >>> 1);
                t_addr    = AW'((blo_reg + bhi_reg) >>> 1);
            end
            ST_SRCH_WAIT:
            begin
                t_addr = AW'(bmid_reg);
            end
            ST_SRCH_CMP:
            begin
                if (kt == qkey_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = t_rd[PosBits-1:0];
                end
                else if (kt > qkey_reg)
                begin
                    bhi_next = $signed({1'b0, bmid_reg} - (CW+1)'(1));
                end
                else
                begin
                    blo_next = $signed({1'b0, bmid_reg} + (CW+1)'(1));
                end
            end
            ST_RESULT: ;
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.found) && $stable(rsp.position))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SRCH_INIT |-> sorted_reg)
        else $error("search on unsorted table");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.found |-> rsp.position == '0)
        else $error("nonzero position on miss");
endmodule
`default_nettype wire
